// ===== design/bounded_doubly_linked_list_defines.svh =====
// Assertion macros shared by the linked list RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_DEFINES_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BDLL_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BDLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bdll_pkg.sv =====
// Types and fixed constants of the bounded doubly linked list.
// Used by the node memory and the top level; depends on nothing.
package bdll_pkg;

   localparam int ITEM_BITS  = 32;
   localparam int POS_BITS   = 5;
   localparam int TOTAL_BITS = 5;

   typedef enum logic [2:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_BACK  = 3'd1,
      ACT_INS_POS   = 3'd2,
      ACT_REM_FRONT = 3'd3,
      ACT_REM_BACK  = 3'd4,
      ACT_REM_VALUE = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_RANGE   = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_MISSING = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      action_type                   action;
      logic signed [ITEM_BITS-1:0]  item_value;
      logic [POS_BITS-1:0]          position;
   } req_type;

   typedef struct packed {
      status_type                   status;
      logic [TOTAL_BITS-1:0]        entry_total;
      logic                         is_empty;
      logic signed [ITEM_BITS-1:0]  front_value;
      logic signed [ITEM_BITS-1:0]  back_value;
   } rsp_type;

   // Field write enables of one node write.
   typedef struct packed {
      logic value;
      logic next;
      logic prev;
   } field_sel_type;

endpackage

// ===== design/bounded_doubly_linked_list.sv =====
// Bounded doubly linked list: top level with the list sequencer.
// Depends on bdll_pkg, bdll_node_ram and bounded_doubly_linked_list_defines.svh.
//
// A request is taken when start is high and busy is low; each request gives
// exactly one response, shown on rsp_item for one cycle with rsp_valid high.
// The receiver cannot stall, so capture the response in that cycle. Busy
// drops in the response cycle, so a new request may be issued alongside it.
// Nodes live in a single-port-read node memory, one link followed per cycle:
// insert at position p walks from the front to the node before the slot,
// and remove by value walks from the front until the first match. There is
// no clearing pass after reset: unused nodes come from a fresh counter,
// freed ones from a free chain threaded through the next links.
`include "bounded_doubly_linked_list_defines.svh"

module bounded_doubly_linked_list #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bdll_pkg::req_type req_item,
   output logic              rsp_valid,
   output bdll_pkg::rsp_type rsp_item
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int LW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (LW > bdll_pkg::POS_BITS) ? LW : bdll_pkg::POS_BITS;
   localparam logic [LW-1:0] NIL = LW'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_ALLOC,
      S_PLACE,
      S_WALK,
      S_NEW,
      S_SEARCH,
      S_FIX_A,
      S_FIX_B,
      S_FREE,
      S_VALFIX
   } state_type;

   state_type                      state_ff, state_in;
   bdll_pkg::action_type           act_ff, act_in;
   logic [VALUE_BITS-1:0]          val_ff, val_in;
   logic [bdll_pkg::POS_BITS-1:0]  pos_ff, pos_in;
   logic [bdll_pkg::POS_BITS-1:0]  k_ff, k_in;
   logic [LW-1:0]                  cur_ff, cur_in;
   logic [LW-1:0]                  n_ff, n_in;
   logic [LW-1:0]                  a_ff, a_in;
   logic [LW-1:0]                  b_ff, b_in;
   logic [LW-1:0]                  head_ff, head_in;
   logic [LW-1:0]                  tail_ff, tail_in;
   logic [LW-1:0]                  count_ff, count_in;
   logic [LW-1:0]                  fresh_ff, fresh_in;
   logic [LW-1:0]                  free_head_ff, free_head_in;
   logic [VALUE_BITS-1:0]          head_val_ff, head_val_in;
   logic [VALUE_BITS-1:0]          tail_val_ff, tail_val_in;
   bdll_pkg::status_type           status_ff, status_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Node memory port
   logic                           wr_en;
   bdll_pkg::field_sel_type        wr_sel;
   logic [AW-1:0]                  wr_addr;
   logic [VALUE_BITS-1:0]          wr_value;
   logic [LW-1:0]                  wr_next;
   logic [LW-1:0]                  wr_prev;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [VALUE_BITS-1:0]          rd_value;
   logic [LW-1:0]                  rd_next;
   logic [LW-1:0]                  rd_prev;

   logic                           is_ins;
   logic                           fin;
   bdll_pkg::status_type           fin_code;

   bdll_node_ram #(
      .DEPTH      (CAPACITY),
      .VALUE_BITS (VALUE_BITS),
      .LINK_BITS  (LW)
   ) u_node_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_sel   (wr_sel),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_next  (wr_next),
      .wr_prev  (wr_prev),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_next  (rd_next),
      .rd_prev  (rd_prev)
   );

   assign is_ins = (act_ff == bdll_pkg::ACT_INS_FRONT) ||
                   (act_ff == bdll_pkg::ACT_INS_BACK)  ||
                   (act_ff == bdll_pkg::ACT_INS_POS);

   // Sequencer: a_ff and b_ff are the neighbours either side of node n_ff.
   // Inserts write the new node, then patch a and b; removes read the node,
   // patch a and b, push the node on the free chain and refetch the value
   // of a new front or back.
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      free_head_in = free_head_ff;
      head_val_in  = head_val_ff;
      tail_val_in  = tail_val_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      fin          = 1'b0;
      fin_code     = bdll_pkg::ST_OK;

      wr_en    = 1'b0;
      wr_sel   = '0;
      wr_addr  = n_ff[AW-1:0];
      wr_value = val_ff;
      wr_next  = b_ff;
      wr_prev  = a_ff;
      rd_en    = 1'b0;
      rd_addr  = cur_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in   = req_item.action;
               val_in   = VALUE_BITS'($unsigned(req_item.item_value));
               pos_in   = req_item.position;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            case (act_ff)
               bdll_pkg::ACT_INS_FRONT, bdll_pkg::ACT_INS_BACK,
               bdll_pkg::ACT_INS_POS: begin
                  // Range check ranks ahead of the full check.
                  if ((act_ff == bdll_pkg::ACT_INS_POS) &&
                      (CMPW'(pos_ff) > CMPW'(count_ff))) begin
                     fin      = 1'b1;
                     fin_code = bdll_pkg::ST_RANGE;
                  end else if (count_ff == NIL) begin
                     fin      = 1'b1;
                     fin_code = bdll_pkg::ST_FULL;
                  end else if (fresh_ff != NIL) begin
                     n_in     = fresh_ff;
                     fresh_in = fresh_ff + 1'b1;
                     state_in = S_PLACE;
                  end else begin
                     // Pop the free chain: fetch the link of its head.
                     rd_en    = 1'b1;
                     rd_addr  = free_head_ff[AW-1:0];
                     state_in = S_ALLOC;
                  end
               end
               bdll_pkg::ACT_REM_FRONT, bdll_pkg::ACT_REM_BACK,
               bdll_pkg::ACT_REM_VALUE: begin
                  if (count_ff == '0) begin
                     fin      = 1'b1;
                     fin_code = bdll_pkg::ST_EMPTY;
                  end else begin
                     cur_in   = (act_ff == bdll_pkg::ACT_REM_BACK) ? tail_ff : head_ff;
                     rd_en    = 1'b1;
                     rd_addr  = cur_in[AW-1:0];
                     state_in = S_SEARCH;
                  end
               end
               default: begin
                  // Undefined action: report the list untouched.
                  fin      = 1'b1;
                  fin_code = bdll_pkg::ST_OK;
               end
            endcase
         end

         S_ALLOC: begin
            n_in         = free_head_ff;
            free_head_in = rd_next;
            state_in     = S_PLACE;
         end

         S_PLACE: begin
            case (act_ff)
               bdll_pkg::ACT_INS_FRONT: begin
                  a_in     = NIL;
                  b_in     = head_ff;
                  state_in = S_NEW;
               end
               bdll_pkg::ACT_INS_BACK: begin
                  a_in     = tail_ff;
                  b_in     = NIL;
                  state_in = S_NEW;
               end
               default: begin
                  if (pos_ff == '0) begin
                     a_in     = NIL;
                     b_in     = head_ff;
                     state_in = S_NEW;
                  end else begin
                     cur_in   = head_ff;
                     k_in     = pos_ff;
                     rd_en    = 1'b1;
                     rd_addr  = head_ff[AW-1:0];
                     state_in = S_WALK;
                  end
               end
            endcase
         end

         S_WALK: begin
            // Read data holds node cur; stop on the node before the slot.
            if (k_ff == bdll_pkg::POS_BITS'(1)) begin
               a_in     = cur_ff;
               b_in     = rd_next;
               state_in = S_NEW;
            end else begin
               cur_in  = rd_next;
               k_in    = k_ff - 1'b1;
               rd_en   = 1'b1;
               rd_addr = rd_next[AW-1:0];
            end
         end

         S_NEW: begin
            wr_en    = 1'b1;
            wr_sel   = '{value: 1'b1, next: 1'b1, prev: 1'b1};
            count_in = count_ff + 1'b1;
            if (a_ff == NIL) head_val_in = val_ff;
            if (b_ff == NIL) tail_val_in = val_ff;
            state_in = S_FIX_A;
         end

         S_SEARCH: begin
            if ((act_ff != bdll_pkg::ACT_REM_VALUE) || (rd_value == val_ff)) begin
               n_in     = cur_ff;
               a_in     = rd_prev;
               b_in     = rd_next;
               state_in = S_FIX_A;
            end else if (rd_next == NIL) begin
               fin      = 1'b1;
               fin_code = bdll_pkg::ST_MISSING;
            end else begin
               cur_in  = rd_next;
               rd_en   = 1'b1;
               rd_addr = rd_next[AW-1:0];
            end
         end

         S_FIX_A: begin
            if (a_ff != NIL) begin
               wr_en   = 1'b1;
               wr_sel  = '{value: 1'b0, next: 1'b1, prev: 1'b0};
               wr_addr = a_ff[AW-1:0];
               wr_next = is_ins ? n_ff : b_ff;
            end else begin
               head_in = is_ins ? n_ff : b_ff;
            end
            state_in = S_FIX_B;
         end

         S_FIX_B: begin
            if (b_ff != NIL) begin
               wr_en   = 1'b1;
               wr_sel  = '{value: 1'b0, next: 1'b0, prev: 1'b1};
               wr_addr = b_ff[AW-1:0];
               wr_prev = is_ins ? n_ff : a_ff;
            end else begin
               tail_in = is_ins ? n_ff : a_ff;
            end
            if (is_ins) begin
               fin      = 1'b1;
               fin_code = bdll_pkg::ST_OK;
            end else begin
               state_in = S_FREE;
            end
         end

         S_FREE: begin
            // Push the node on the free chain; fetch a new end value if needed.
            wr_en        = 1'b1;
            wr_sel       = '{value: 1'b0, next: 1'b1, prev: 1'b0};
            wr_next      = free_head_ff;
            free_head_in = n_ff;
            count_in     = count_ff - 1'b1;
            if ((a_ff == NIL) && (b_ff != NIL)) begin
               rd_en    = 1'b1;
               rd_addr  = b_ff[AW-1:0];
               state_in = S_VALFIX;
            end else if ((b_ff == NIL) && (a_ff != NIL)) begin
               rd_en    = 1'b1;
               rd_addr  = a_ff[AW-1:0];
               state_in = S_VALFIX;
            end else begin
               fin      = 1'b1;
               fin_code = bdll_pkg::ST_OK;
            end
         end

         S_VALFIX: begin
            if (a_ff == NIL) head_val_in = rd_value;
            else             tail_val_in = rd_value;
            fin      = 1'b1;
            fin_code = bdll_pkg::ST_OK;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         status_in    = fin_code;
         rsp_valid_in = 1'b1;
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         count_ff     <= '0;
         fresh_ff     <= '0;
         free_head_ff <= NIL;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         free_head_ff <= free_head_in;
      end
      // Payload: no reset needed.
      act_ff      <= act_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      n_ff        <= n_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      head_val_ff <= head_val_in;
      tail_val_ff <= tail_val_in;
      status_ff   <= status_in;
   end

   // Response fields come straight from held state; they are stable for the
   // strobe cycle because nothing changes until the next request is taken.
   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_item.status      = status_ff;
   assign rsp_item.entry_total = (bdll_pkg::TOTAL_BITS)'(count_ff);
   assign rsp_item.is_empty    = (count_ff == '0);
   assign rsp_item.front_value = (head_ff == NIL) ? '0 :
                                 (bdll_pkg::ITEM_BITS)'(head_val_ff);
   assign rsp_item.back_value  = (tail_ff == NIL) ? '0 :
                                 (bdll_pkg::ITEM_BITS)'(tail_val_ff);

   `BDLL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
      "accepted request left sequencer idle")
   `BDLL_ASSERT_IMPLIES(a_strobe_idle, clock, reset, rsp_valid, !busy,
      "response strobe while busy")
   `BDLL_ASSERT_IMPLIES(a_empty_links, clock, reset, !busy,
      ((count_ff == '0) == (head_ff == NIL)) && ((count_ff == '0) == (tail_ff == NIL)),
      "count disagrees with end links")
   `BDLL_ASSERT_IMPLIES(a_full_status, clock, reset,
      rsp_valid && (status_ff == bdll_pkg::ST_FULL), count_ff == NIL,
      "full status on a list with room")
   `BDLL_ASSERT_IMPLIES(a_pool_bound, clock, reset, !busy, count_ff <= fresh_ff,
      "more entries than nodes handed out")

endmodule

// ===== design/bdll_node_ram.sv =====
// Node pool memory: value, next link and prev link per node, one write
// and one registered read per cycle. Depends on bdll_pkg.
module bdll_node_ram #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32,
   parameter int LINK_BITS  = 5
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  bdll_pkg::field_sel_type       wr_sel,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [VALUE_BITS-1:0]         wr_value,
   input  logic [LINK_BITS-1:0]          wr_next,
   input  logic [LINK_BITS-1:0]          wr_prev,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [VALUE_BITS-1:0]         rd_value,
   output logic [LINK_BITS-1:0]          rd_next,
   output logic [LINK_BITS-1:0]          rd_prev
);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [LINK_BITS-1:0]  next;
      logic [LINK_BITS-1:0]  prev;
   } node_type;

   node_type mem [DEPTH];

   logic [VALUE_BITS-1:0] rd_value_ff, rd_value_in;
   logic [LINK_BITS-1:0]  rd_next_ff, rd_next_in;
   logic [LINK_BITS-1:0]  rd_prev_ff, rd_prev_in;
   logic                  same_addr;

   // Forward fields written in the same cycle as the read.
   always_comb begin
      same_addr   = wr_en && (wr_addr == rd_addr);
      rd_value_in = (same_addr && wr_sel.value) ? wr_value : mem[rd_addr].value;
      rd_next_in  = (same_addr && wr_sel.next)  ? wr_next  : mem[rd_addr].next;
      rd_prev_in  = (same_addr && wr_sel.prev)  ? wr_prev  : mem[rd_addr].prev;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_sel.value) mem[wr_addr].value <= wr_value;
         if (wr_sel.next)  mem[wr_addr].next  <= wr_next;
         if (wr_sel.prev)  mem[wr_addr].prev  <= wr_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value_ff <= rd_value_in;
         rd_next_ff  <= rd_next_in;
         rd_prev_ff  <= rd_prev_in;
      end
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

// ===== tb/sv/bounded_doubly_linked_list_tb.sv =====
// Self-checking bench for the bounded doubly linked list: list operations in, one snapshot out.
// Depends on bdll_pkg and the bounded_doubly_linked_list RTL; a queue mirrors the list contents.
module bounded_doubly_linked_list_tb;
   import bdll_pkg::*;

   localparam int CAPACITY   = 16;
   localparam int VALUE_BITS = 32;

   // One list operation waiting to be issued, with the idle cycles to hold
   // before it and a flag that holds it until every snapshot has come back.
   typedef struct {
      req_type op;
      int      idle;
      bit      settle;
   } list_op;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_item  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   list_op              op_queue[$];        // operations not yet accepted
   rsp_type             snapshot_queue[$];  // snapshots still owed by the block
   logic signed [31:0]  list_image[$];      // mirror of the list, front first
   int                  idle_left      = 0;
   int                  mismatch_count = 0;

   bounded_doubly_linked_list #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hold reset high at the start of the run, then release it on a falling edge.
   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
   end

   // Apply one list operation to the mirror and return the snapshot the block
   // must report: status, count, empty flag, front and back (zero when empty).
   function automatic rsp_type apply_list_op(req_type op);
      rsp_type snap;
      int      hit;
      snap        = '0;
      snap.status = ST_OK;
      hit         = -1;
      case (op.action)
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
            // The range check wins over the full check.
            if (op.action == ACT_INS_POS && int'(op.position) > list_image.size()) begin
               snap.status = ST_RANGE;
            end else if (list_image.size() >= CAPACITY) begin
               snap.status = ST_FULL;
            end else if (op.action == ACT_INS_FRONT) begin
               list_image.push_front(op.item_value);
            end else if (op.action == ACT_INS_BACK) begin
               list_image.push_back(op.item_value);
            end else begin
               list_image.insert(int'(op.position), op.item_value);
            end
         end
         ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_VALUE: begin
            if (list_image.size() == 0) begin
               snap.status = ST_EMPTY;
            end else if (op.action == ACT_REM_FRONT) begin
               void'(list_image.pop_front());
            end else if (op.action == ACT_REM_BACK) begin
               void'(list_image.pop_back());
            end else begin
               // Drop only the first entry that matches, searching from the front.
               foreach (list_image[i])
                  if (hit < 0 && list_image[i] == op.item_value) hit = i;
               if (hit < 0) snap.status = ST_MISSING;
               else list_image.delete(hit);
            end
         end
         default: ;
      endcase
      snap.entry_total = TOTAL_BITS'(list_image.size());
      snap.is_empty    = (list_image.size() == 0);
      if (list_image.size() != 0) begin
         snap.front_value = list_image[0];
         snap.back_value  = list_image[$];
      end
      return snap;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
   endtask

   task automatic queue_op(action_type act, logic [31:0] val, logic [4:0] pos,
                           int idle, bit settle);
      list_op entry;
      entry.op.action     = act;
      entry.op.item_value = val;
      entry.op.position   = pos;
      entry.idle          = idle;
      entry.settle        = settle;
      op_queue.push_back(entry);
   endtask

   // Driver: change inputs on the falling edge only, one assignment per signal.
   // Count down the idle gap first, then present the head of the queue; a
   // settling request waits until the block owes no snapshots.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (idle_left > 0) begin
         idle_left--;
         start <= 1'b0;
      end else if (op_queue.size() != 0 &&
                   !(op_queue[0].settle && snapshot_queue.size() != 0)) begin
         start    <= 1'b1;
         req_item <= op_queue[0].op;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: check a response against the oldest owed snapshot, then note a
   // request accepted on this edge. The response is registered from a later
   // sequencer state, so a request never answers on its own acceptance edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (snapshot_queue.size() == 0) begin
            flag_mismatch("unexpected response status", '0, rsp_item.status);
         end else begin
            want = snapshot_queue.pop_front();
            if (rsp_item.status !== want.status)
               flag_mismatch("status", want.status, rsp_item.status);
            if (rsp_item.entry_total !== want.entry_total)
               flag_mismatch("entry_total", want.entry_total, rsp_item.entry_total);
            if (rsp_item.is_empty !== want.is_empty)
               flag_mismatch("is_empty", want.is_empty, rsp_item.is_empty);
            if (rsp_item.front_value !== want.front_value)
               flag_mismatch("front_value", want.front_value, rsp_item.front_value);
            if (rsp_item.back_value !== want.back_value)
               flag_mismatch("back_value", want.back_value, rsp_item.back_value);
         end
      end
      if (!reset && start && !busy) begin
         snapshot_queue.push_back(apply_list_op(req_item));
         void'(op_queue.pop_front());
         idle_left = (op_queue.size() != 0) ? op_queue[0].idle : 0;
      end
   end

   // Stimulus and end of run.
   initial begin
      int                 est;
      int                 mode;
      int                 roll;
      int                 idle;
      action_type         act;
      logic signed [31:0] val;
      logic [4:0]         pos;
      logic signed [31:0] recent[$];

      // Directed: every remove on an empty list, a position past the count.
      queue_op(ACT_REM_FRONT, 32'd0, 5'd0, 0, 1'b0);
      queue_op(ACT_REM_BACK,  32'd0, 5'd0, 0, 1'b0);
      queue_op(ACT_REM_VALUE, 32'd0, 5'd0, 0, 1'b0);
      queue_op(ACT_INS_POS,   32'd7, 5'd1, 0, 1'b0);
      // Fill to capacity, mixing front, back and positional inserts at both ends
      // with the extreme values; the last one puts a known value at the back.
      for (int i = 0; i < CAPACITY; i++) begin
         case (i)
            0: val = 32'sh8000_0000;
            1: val = 32'sh7fff_ffff;
            2: val = -32'sd1;
            3: val = 32'sd0;
            default: val = $urandom;
         endcase
         if (i == CAPACITY - 1) begin
            queue_op(ACT_INS_BACK, 32'sh5a5a_0f0f, 5'd0, 0, 1'b0);
         end else begin
            act = action_type'(i % 3);
            pos = ((i / 3) % 2 == 1) ? 5'(i) : 5'd0;
            queue_op(act, val, pos, 0, 1'b0);
         end
      end
      // Full list: plain insert and an insert at the count both report full.
      queue_op(ACT_INS_FRONT, 32'd1, 5'd0, 0, 1'b0);
      queue_op(ACT_INS_POS,   32'd1, 5'd16, 0, 1'b0);
      // Absent value, then remove the back entry by value, then both ends.
      queue_op(ACT_REM_VALUE, 32'sh1234_5678, 5'd0, 0, 1'b0);
      queue_op(ACT_REM_VALUE, 32'sh5a5a_0f0f, 5'd0, 0, 1'b0);
      queue_op(ACT_REM_FRONT, 32'd0, 5'd0, 0, 1'b0);
      queue_op(ACT_REM_BACK,  32'd0, 5'd0, 0, 1'b0);

      // Random: blocks of 40 requests lean towards filling, draining or neither,
      // so the list swings between empty and full. Track a rough count to keep
      // most positions in range, and reuse recent values so searches mostly hit.
      est = CAPACITY - 4;
      for (int n = 0; n < 1000; n++) begin
         mode = (n / 40) % 3;
         roll = $urandom_range(0, 99);
         if ((mode == 0 && roll < 75) || (mode == 1 && roll < 25) ||
             (mode == 2 && roll < 50)) begin
            act = action_type'($urandom_range(0, 2));
         end else begin
            act = action_type'($urandom_range(3, 5));
         end

         if (act == ACT_REM_VALUE && recent.size() != 0 && $urandom_range(0, 3) != 0) begin
            val = recent[$urandom_range(0, recent.size() - 1)];
         end else begin
            case ($urandom_range(0, 3))
               0: val = $urandom_range(0, 7) - 4;
               1: val = ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
               default: val = $urandom;
            endcase
         end

         if ($urandom_range(0, 7) != 0) pos = 5'($urandom_range(0, est));
         else pos = 5'($urandom_range(0, CAPACITY));

         if (act <= ACT_INS_POS) begin
            recent.push_back(val);
            if (recent.size() > 32) void'(recent.pop_front());
            if (est < CAPACITY) est++;
         end else if (est > 0) begin
            est--;
         end

         // Idle gaps: none in every fourth block, otherwise mostly short, few long.
         roll = $urandom_range(0, 9);
         if ((n / 40) % 4 == 3) idle = 0;
         else if (roll < 7) idle = $urandom_range(0, 3);
         else if (roll < 9) idle = $urandom_range(4, 12);
         else idle = $urandom_range(13, 40);

         queue_op(act, val, pos, idle, (n % 250 == 0));
      end

      // Wait for every request to go in and every snapshot to come back,
      // then hold a little longer to catch any stray response.
      while (op_queue.size() != 0 || snapshot_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && snapshot_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
